// ===== rtl/mvsm_pkg.sv =====
// Shared constants, request/status codes and record types of the voice mixer.
// No dependencies; every other rtl file imports this package.
package mvsm_pkg;

    localparam int NUM_VOICES     = 256;
    localparam int NUM_SOUNDS     = 1024;
    localparam int SAMPLE_FRAMES  = 65536;
    localparam int STEP_FRAC_BITS = 8;

    localparam int VIDX_W  = $clog2(NUM_VOICES);
    localparam int VCNT_W  = $clog2(NUM_VOICES + 1);
    localparam int SID_W   = $clog2(NUM_SOUNDS);
    localparam int NSND_W  = $clog2(NUM_SOUNDS + 1);
    localparam int FADDR_W = $clog2(SAMPLE_FRAMES);
    localparam int ADDR_W  = 16;
    localparam int SMP_W   = 16;
    localparam int LEN_W   = 17;
    localparam int GAIN_W  = 8;
    localparam int STEP_W  = 16;
    localparam int CUR_W   = LEN_W + STEP_FRAC_BITS;
    localparam int VAL_W   = SMP_W + 1;

    // x / 255 == (x * RECIP) >> SCALE_SHIFT, exact for x < 2^23
    localparam int          MAG_W       = 24;
    localparam logic [23:0] RECIP       = 24'h808081;
    localparam int          SCALE_SHIFT = 31;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;
    localparam logic [1:0] REQ_MIX    = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_VOICE = 2'd1;
    localparam logic [1:0] STAT_BAD_ID   = 2'd2;
    localparam logic [1:0] STAT_TABLE    = 2'd3;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [ADDR_W-1:0]       address;
        logic signed [SMP_W-1:0] left_sample;
        logic signed [SMP_W-1:0] right_sample;
        logic [LEN_W-1:0]        sound_length;
        logic [9:0]              sound_id;
        logic [GAIN_W-1:0]       volume;
        logic [STEP_W-1:0]       speed;
    } t_request;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_out;
        logic signed [SMP_W-1:0] right_out;
        logic [1:0]              status;
        logic [9:0]              new_sound_id;
        logic [7:0]              voice_index;
    } t_result;

    typedef struct packed {
        logic [SID_W-1:0]  sound;
        logic [CUR_W-1:0]  cursor;
        logic [GAIN_W-1:0] gain;
        logic [STEP_W-1:0] step;
    } t_voice;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  frames;
    } t_sound;

endpackage

// ===== rtl/mvsm_sample_mem.sv =====
// Stereo sample frame store: one write port, one read port, registered read.
// Depends on mvsm_pkg.
module mvsm_sample_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [mvsm_pkg::FADDR_W-1:0] i_waddr,
    input  logic [2*mvsm_pkg::SMP_W-1:0] i_wdata,
    input  logic [mvsm_pkg::FADDR_W-1:0] i_raddr,
    output logic [2*mvsm_pkg::SMP_W-1:0] o_rdata
);
    import mvsm_pkg::*;

    logic [2*SMP_W-1:0] r_mem [SAMPLE_FRAMES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/mvsm_scale.sv =====
// Two-stage gain unit: sample * volume, then divide by 255 toward zero.
// Depends on mvsm_pkg.
module mvsm_scale (
    input  logic                              i_clk,
    input  logic signed [mvsm_pkg::SMP_W-1:0]  i_sample,
    input  logic [mvsm_pkg::GAIN_W-1:0]        i_gain,
    output logic signed [mvsm_pkg::VAL_W-1:0]  o_value
);
    import mvsm_pkg::*;

    localparam int PROD_W = SMP_W + GAIN_W + 1;

    logic signed [PROD_W-1:0] r_prod;
    logic [2*MAG_W-1:0]       r_scaled;
    logic                     r_neg;
    logic [MAG_W-1:0]         mag;
    logic [SMP_W-1:0]         quot;

    always_comb begin
        mag  = r_prod[PROD_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);
        quot = r_scaled[SCALE_SHIFT +: SMP_W];
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= i_sample * $signed({1'b0, i_gain});
        r_scaled <= mag * RECIP;
        r_neg    <= r_prod[PROD_W-1];
    end

    assign o_value = r_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

// ===== rtl/mvsm_core.sv =====
// Request sequencer: sound table and voice memories, voice scan and the
// mix pipeline. Depends on mvsm_pkg, mvsm_sample_mem and mvsm_scale.
module mvsm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  mvsm_pkg::t_request i_req,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output mvsm_pkg::t_result  o_res
);
    import mvsm_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WRITE  = 3'd1;
    localparam logic [2:0] ST_APPEND = 3'd2;
    localparam logic [2:0] ST_START  = 3'd3;
    localparam logic [2:0] ST_MIX    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]              r_state, n_state;
    t_request                r_req;
    t_result                 r_res, n_res;
    logic [VCNT_W-1:0]       r_vcnt, n_vcnt;
    logic [NSND_W-1:0]       r_nsnd, n_nsnd;
    logic signed [SMP_W-1:0] r_acc_l, n_acc_l, r_acc_r, n_acc_r;
    logic [NUM_VOICES-1:0]   r_active;

    t_voice r_voice_mem [NUM_VOICES];
    t_sound r_snd_mem [NUM_SOUNDS];
    t_voice r_vrd;
    t_sound r_srd;

    // mix pipeline: valid and last-voice markers per stage
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_l1, r_l2, r_l3, r_l4, r_l5;
    logic [VIDX_W-1:0] r_idx1, r_idx2;
    t_voice            r_p2;
    logic [GAIN_W-1:0] r_g3;

    logic              accept, issue, start_hit, s2_end, s2_live;
    logic [VIDX_W-1:0] scan_idx;
    logic              vm_we, snd_we, smp_we;
    logic [VIDX_W-1:0] vm_waddr;
    t_voice            vm_wdata;
    logic [CUR_W-1:0]  end_pos, step_ext;
    logic [FADDR_W-1:0] frame;
    logic [2*SMP_W-1:0] smp_rdata;
    logic signed [VAL_W-1:0] val_l, val_r;

    function automatic logic signed [SMP_W-1:0] sat_add(
        input logic signed [SMP_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [SMP_W+1:0] s;
        s = SMP_W'(0) + (SMP_W+2)'(a) + (SMP_W+2)'(b);
        if (s > (SMP_W+2)'(32767)) begin
            return 16'sd32767;
        end else if (s < -(SMP_W+2)'(32768)) begin
            return -16'sd32768;
        end
        return s[SMP_W-1:0];
    endfunction

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;
    assign scan_idx    = r_vcnt[VIDX_W-1:0];
    assign issue       = (r_state == ST_MIX) && (r_vcnt < VCNT_W'(NUM_VOICES));
    assign start_hit   = (r_state == ST_START) && (NSND_W'(r_req.sound_id) < r_nsnd)
                         && !r_active[scan_idx];

    // stage 2: end test, sample address, cursor advance
    always_comb begin
        end_pos  = {r_srd.frames, STEP_FRAC_BITS'(0)};
        s2_end   = r_p2.cursor >= end_pos;
        s2_live  = r_v2 && !s2_end;
        frame    = r_srd.start + r_p2.cursor[STEP_FRAC_BITS +: FADDR_W];
        step_ext = (r_p2.step == '0) ? CUR_W'(1 << STEP_FRAC_BITS) : CUR_W'(r_p2.step);
    end

    always_comb begin
        vm_we    = 1'b0;
        vm_waddr = r_idx2;
        vm_wdata = r_p2;
        if (start_hit) begin
            vm_we    = 1'b1;
            vm_waddr = scan_idx;
            vm_wdata = '{sound: r_req.sound_id, cursor: '0, gain: r_req.volume,
                         step: r_req.speed};
        end else if (s2_live) begin
            vm_we           = 1'b1;
            vm_wdata.cursor = r_p2.cursor + step_ext;
        end
    end

    assign snd_we = (r_state == ST_APPEND) && (r_nsnd < NSND_W'(NUM_SOUNDS))
                    && (r_req.sound_length != '0);
    assign smp_we = (r_state == ST_WRITE);

    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            r_voice_mem[vm_waddr] <= vm_wdata;
        end
        r_vrd <= r_voice_mem[scan_idx];
        if (snd_we) begin
            r_snd_mem[r_nsnd[SID_W-1:0]] <= '{start: r_req.address,
                                             frames: r_req.sound_length};
        end
        r_srd <= r_snd_mem[r_vrd.sound];
    end

    mvsm_sample_mem u_smp (
        .i_clk   (i_clk),
        .i_we    (smp_we),
        .i_waddr (FADDR_W'(r_req.address)),
        .i_wdata ({r_req.right_sample, r_req.left_sample}),
        .i_raddr (frame),
        .o_rdata (smp_rdata)
    );

    mvsm_scale u_scale_l (
        .i_clk    (i_clk),
        .i_sample (smp_rdata[SMP_W-1:0]),
        .i_gain   (r_g3),
        .o_value  (val_l)
    );

    mvsm_scale u_scale_r (
        .i_clk    (i_clk),
        .i_sample (smp_rdata[2*SMP_W-1:SMP_W]),
        .i_gain   (r_g3),
        .o_value  (val_r)
    );

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_vcnt  = r_vcnt;
        n_nsnd  = r_nsnd;
        n_acc_l = r_acc_l;
        n_acc_r = r_acc_r;
        if (r_v5) begin
            n_acc_l = sat_add(r_acc_l, val_l);
            n_acc_r = sat_add(r_acc_r, val_r);
        end
        unique case (r_state)
            ST_IDLE: begin
                n_res  = '0;
                n_vcnt = '0;
                if (accept) begin
                    n_acc_l = '0;
                    n_acc_r = '0;
                    unique case (i_req.req_type)
                        REQ_WRITE:  n_state = ST_WRITE;
                        REQ_APPEND: n_state = ST_APPEND;
                        REQ_START:  n_state = ST_START;
                        REQ_MIX:    n_state = ST_MIX;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: n_state = ST_DONE;
            ST_APPEND: begin
                n_state = ST_DONE;
                if (snd_we) begin
                    n_res.new_sound_id = 10'(r_nsnd);
                    n_nsnd             = r_nsnd + 1'b1;
                end else begin
                    n_res.status = STAT_TABLE;
                end
            end
            ST_START: begin
                if (NSND_W'(r_req.sound_id) >= r_nsnd) begin
                    n_res.status = STAT_BAD_ID;
                    n_state      = ST_DONE;
                end else if (start_hit) begin
                    n_res.voice_index = 8'(scan_idx);
                    n_state           = ST_DONE;
                end else if (r_vcnt == VCNT_W'(NUM_VOICES - 1)) begin
                    n_res.status = STAT_NO_VOICE;
                    n_state      = ST_DONE;
                end else begin
                    n_vcnt = r_vcnt + 1'b1;
                end
            end
            ST_MIX: begin
                if (issue) begin
                    n_vcnt = r_vcnt + 1'b1;
                end
                if (r_l5) begin
                    n_res.left_out  = n_acc_l;
                    n_res.right_out = n_acc_r;
                    n_state         = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_nsnd   <= '0;
            r_active <= '0;
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
            r_l1 <= 1'b0; r_l2 <= 1'b0; r_l3 <= 1'b0; r_l4 <= 1'b0; r_l5 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nsnd  <= n_nsnd;
            if (start_hit) begin
                r_active[scan_idx] <= 1'b1;
            end else if (r_v2 && s2_end) begin
                r_active[r_idx2] <= 1'b0;
            end
            r_v1 <= issue && r_active[scan_idx];
            r_l1 <= issue && (r_vcnt == VCNT_W'(NUM_VOICES - 1));
            r_v2 <= r_v1;    r_l2 <= r_l1;
            r_v3 <= s2_live; r_l3 <= r_l2;
            r_v4 <= r_v3;    r_l4 <= r_l3;
            r_v5 <= r_v4;    r_l5 <= r_l4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_res   <= n_res;
        r_vcnt  <= n_vcnt;
        r_acc_l <= n_acc_l;
        r_acc_r <= n_acc_r;
        r_idx1  <= scan_idx;
        r_idx2  <= r_idx1;
        r_p2    <= r_vrd;
        r_g3    <= r_p2.gain;
    end

    // a voice in flight was active when issued and nothing frees it early
    a_live_voice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> r_active[r_idx2])
        else $error("mix pipeline carries an inactive voice");

    a_snd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nsnd <= NSND_W'(NUM_SOUNDS))
        else $error("sound count beyond table size");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(r_v1 || r_v2 || r_v3 || r_v4 || r_v5 || r_l5))
        else $error("mix pipeline busy while idle");

    a_last_in_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_l5 |-> (r_state == ST_MIX))
        else $error("last voice marker outside a mix");

endmodule

// ===== rtl/multi_voice_sample_mixer.sv =====
// A mix request feeds one voice per cycle through the mix pipeline. Throughput:
// one item at a time; next transfer is taken as soon as the sequencer is idle,
// even while the previous result waits in the output reg.
// Reset (i_rst_n low, synchronous) frees all voices and empties the sound
// table; sample and sound memories keep contents and need no clearing pass.
module multi_voice_sample_mixer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // address, left_sample, right_sample, sound_length, sound_id, volume, speed
    input  logic [103:0] i_s_tdata,
    // req_type
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // left_out, right_out, status, new_sound_id, voice_index
    output logic [55:0]  o_m_tdata
);
    import mvsm_pkg::*;

    t_request req;
    t_result  res, r_out;
    logic     res_valid, res_ready, r_out_valid;

    always_comb begin
        req.req_type     = i_s_tuser;
        req.address      = i_s_tdata[15:0];
        req.left_sample  = i_s_tdata[31:16];
        req.right_sample = i_s_tdata[47:32];
        req.sound_length = i_s_tdata[64:48];
        req.sound_id     = i_s_tdata[74:65];
        req.volume       = i_s_tdata[82:75];
        req.speed        = i_s_tdata[98:83];
    end

    mvsm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out.voice_index, r_out.new_sound_id, r_out.status,
                         r_out.right_out, r_out.left_out};

endmodule

// ===== tb/mvsm_checker.sv =====
// Scoreboard for the voice mixer: watches both stream channels, keeps a shadow
// of the sample memory, sound table and voices, and checks every result.
// Depends on mvsm_pkg for widths, request/status codes and record types.
`timescale 1ns / 100ps

module mvsm_checker
    import mvsm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [103:0] i_s_tdata,
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [55:0]  i_m_tdata,
    output int           o_outstanding,
    output int           o_errors
);

    logic [31:0] frame_mem [SAMPLE_FRAMES];
    t_sound      sound_tab [NUM_SOUNDS];
    int unsigned n_sounds;
    bit          voice_on  [NUM_VOICES];
    t_voice      voice_tab [NUM_VOICES];
    t_result     answers_due [$];

    initial begin
        o_outstanding = 0;
        o_errors      = 0;
    end

    function automatic int sat16(int x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    // gain = volume / 255, truncated toward zero
    function automatic int apply_gain(int s, int g);
        return (s * g) / 255;
    endfunction

    function automatic t_result mix_request(t_request r);
        t_result res;
        t_sound  sd;
        logic [31:0] word;
        logic [15:0] frame;
        int  lo, ro, slot;
        bit  found;
        res   = '0;
        lo    = 0;
        ro    = 0;
        found = 0;
        slot  = 0;
        case (r.req_type)
            REQ_WRITE: frame_mem[r.address] = {r.right_sample, r.left_sample};
            REQ_APPEND: begin
                if (n_sounds >= NUM_SOUNDS || r.sound_length == 0) begin
                    res.status = STAT_TABLE;
                end else begin
                    res.new_sound_id = 10'(n_sounds);
                    sound_tab[n_sounds].start  = r.address;
                    sound_tab[n_sounds].frames = r.sound_length;
                    n_sounds++;
                end
            end
            REQ_START: begin
                if (r.sound_id >= n_sounds) begin
                    res.status = STAT_BAD_ID;
                end else begin
                    for (int v = 0; v < NUM_VOICES; v++)
                        if (!found && !voice_on[v]) begin
                            found = 1;
                            slot  = v;
                        end
                    if (!found) begin
                        res.status = STAT_NO_VOICE;
                    end else begin
                        voice_on[slot]         = 1;
                        voice_tab[slot].sound  = r.sound_id;
                        voice_tab[slot].cursor = '0;
                        voice_tab[slot].gain   = r.volume;
                        voice_tab[slot].step   = r.speed;
                        res.voice_index        = 8'(slot);
                    end
                end
            end
            default: begin
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (voice_on[v]) begin
                        sd = sound_tab[voice_tab[v].sound];
                        if (voice_tab[v].cursor >= {sd.frames, 8'h00}) begin
                            voice_on[v] = 0;
                        end else begin
                            frame = 16'(sd.start +
                                        voice_tab[v].cursor[CUR_W-1:STEP_FRAC_BITS]);
                            word  = frame_mem[frame];
                            lo = sat16(lo + apply_gain($signed(word[15:0]),
                                                       int'(voice_tab[v].gain)));
                            ro = sat16(ro + apply_gain($signed(word[31:16]),
                                                       int'(voice_tab[v].gain)));
                            // step 0 stands for 1.0
                            voice_tab[v].cursor += CUR_W'((voice_tab[v].step == 0) ?
                                (1 << STEP_FRAC_BITS) : voice_tab[v].step);
                        end
                    end
                end
                res.left_out  = lo[15:0];
                res.right_out = ro[15:0];
            end
        endcase
        return res;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_request req;
        t_result  exp_r, got_r;
        if (!i_rst_n) begin
            n_sounds = 0;
            foreach (voice_on[v]) voice_on[v] = 0;
            answers_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                req.req_type     = i_s_tuser;
                req.address      = i_s_tdata[15:0];
                req.left_sample  = i_s_tdata[31:16];
                req.right_sample = i_s_tdata[47:32];
                req.sound_length = i_s_tdata[64:48];
                req.sound_id     = i_s_tdata[74:65];
                req.volume       = i_s_tdata[82:75];
                req.speed        = i_s_tdata[98:83];
                answers_due.push_back(mix_request(req));
            end
            if (i_m_tvalid && i_m_tready) begin
                got_r.left_out     = i_m_tdata[15:0];
                got_r.right_out    = i_m_tdata[31:16];
                got_r.status       = i_m_tdata[33:32];
                got_r.new_sound_id = i_m_tdata[43:34];
                got_r.voice_index  = i_m_tdata[51:44];
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, got %h",
                             $time, i_m_tdata);
                    o_errors++;
                end else begin
                    exp_r = answers_due.pop_front();
                    check_field("left_out", exp_r.left_out, got_r.left_out);
                    check_field("right_out", exp_r.right_out, got_r.right_out);
                    check_field("status", exp_r.status, got_r.status);
                    check_field("new_sound_id", exp_r.new_sound_id, got_r.new_sound_id);
                    check_field("voice_index", exp_r.voice_index, got_r.voice_index);
                end
            end
        end
        o_outstanding = answers_due.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the voice mixer testbench: clock, reset, request stimulus with bursts
// and gaps, result-side stalls, and the verdict. Needs mvsm_pkg, the mixer
// and mvsm_checker.
`timescale 1ns / 100ps

module tb;
    import mvsm_pkg::*;

    localparam logic [15:0] REGION_BASE = 16'hFFF0;  // written frames wrap past 0xFFFF
    localparam int          REGION_LEN  = 64;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = REQ_WRITE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    int           outstanding;
    int           errors;

    bit hold_now  = 0;
    int hold_left = 0;
    int rx_cycle  = 0;
    int rx_mode   = 0;

    int n_defined = 0;
    int playable_ids [$];

    multi_voice_sample_mixer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    mvsm_checker scoreboard (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #10ms;
        $display("[multi_voice_sample_mixer] ERROR");
        $finish;
    end

    // result side: stall pattern picked at random among three modes, plus long hold-offs
    always @(negedge clk) begin
        if (hold_now) begin
            hold_now  = 0;
            hold_left = 1500;
        end
        rx_cycle++;
        if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic t_request mk(logic [1:0] kind, logic [15:0] addr, logic [15:0] l,
                                    logic [15:0] r, logic [16:0] len, logic [9:0] sid,
                                    logic [7:0] vol, logic [15:0] spd);
        t_request q;
        q.req_type     = kind;
        q.address      = addr;
        q.left_sample  = l;
        q.right_sample = r;
        q.sound_length = len;
        q.sound_id     = sid;
        q.volume       = vol;
        q.speed        = spd;
        return q;
    endfunction

    // one transfer; valid stays high afterwards until a gap lowers it
    task automatic send(t_request q);
        logic [15:0] off;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= q.req_type;
        s_tdata  <= {5'b0, q.speed, q.volume, q.sound_id, q.sound_length,
                     q.right_sample, q.left_sample, q.address};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        // mirror the sound table; only sounds inside the written region get played
        if (q.req_type == REQ_APPEND && q.sound_length != 0 && n_defined < NUM_SOUNDS) begin
            off = q.address - REGION_BASE;
            if (off < REGION_LEN && off + q.sound_length <= REGION_LEN)
                playable_ids.push_back(n_defined);
            n_defined++;
        end
    endtask

    task automatic gap(int n);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    function automatic t_request playable_append();
        int o;
        o = $urandom_range(0, REGION_LEN - 1);
        return mk(REQ_APPEND, 16'(REGION_BASE + o), 16'($urandom), 16'($urandom),
                  17'($urandom_range(1, REGION_LEN - o)), 10'($urandom), 8'($urandom),
                  16'($urandom));
    endfunction

    function automatic t_request random_request();
        t_request q;
        int k, pick;
        k = $urandom_range(0, 99);
        q = mk(REQ_MIX, 16'($urandom), 16'($urandom), 16'($urandom),
               17'($urandom_range(0, 65536)), 10'($urandom), 8'($urandom), 16'($urandom));
        if (k < 20) begin
            q.req_type = REQ_WRITE;
            if ($urandom_range(0, 1)) q.address = 16'(REGION_BASE + $urandom_range(0, 63));
        end else if (k < 35) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) q = playable_append();
            else q.req_type = REQ_APPEND;
            if (pick == 9) q.sound_length = 0;
            else if (pick == 8) q.sound_length = 17'($urandom_range(1, 65536));
        end else if (k < 60) begin
            q.req_type = REQ_START;
            if ($urandom_range(0, 9) < 3) q.speed = 0;
            if ($urandom_range(0, 6) != 0 && playable_ids.size() > 0)
                q.sound_id = 10'(playable_ids[$urandom_range(0, playable_ids.size() - 1)]);
            else if (n_defined < NUM_SOUNDS)
                q.sound_id = 10'($urandom_range(n_defined, NUM_SOUNDS - 1));
            else
                q.req_type = REQ_MIX;
        end
        return q;
    endfunction

    initial begin
        int burst, long_id;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // fill the playable region, extremes on two of every four frames
        for (int a = 0; a < REGION_LEN; a++) begin
            if (a % 4 == 0)
                send(mk(REQ_WRITE, 16'(REGION_BASE + a), 16'h7FFF, 16'h8000, 0, 0, 0, 0));
            else if (a % 4 == 1)
                send(mk(REQ_WRITE, 16'(REGION_BASE + a), 16'h8000, 16'h7FFF, 0, 0, 0, 0));
            else
                send(mk(REQ_WRITE, 16'(REGION_BASE + a), 16'($urandom), 16'($urandom),
                        0, 0, 0, 0));
        end

        // directed cases
        send(mk(REQ_APPEND, 16'h0010, 0, 0, 17'd0, 0, 0, 0));           // empty length
        send(mk(REQ_APPEND, 16'hFFFE, 0, 0, 17'd4, 0, 0, 0));           // wraps memory end
        send(mk(REQ_APPEND, 16'h1234, 0, 0, 17'd65536, 0, 0, 0));       // longest sound
        send(mk(REQ_START, 0, 0, 0, 0, 10'd1023, 8'd255, 16'h0000));     // unknown id
        send(mk(REQ_START, 0, 0, 0, 0, 10'd0, 8'd255, 16'h0000));        // speed zero
        send(mk(REQ_START, 0, 0, 0, 0, 10'd0, 8'd255, 16'h0080));
        send(mk(REQ_START, 0, 0, 0, 0, 10'd0, 8'd0, 16'hFFFF));
        send(mk(REQ_START, 0, 0, 0, 0, 10'd0, 8'd128, 16'h0180));
        send(mk(REQ_WRITE, 16'h0000, 16'h8000, 16'h8000, 0, 0, 0, 0));
        send(mk(REQ_WRITE, 16'hFFFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0));
        repeat (6) send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0));

        // random part, bursts and gaps
        burst = 0;
        for (int n = 0; n < 60; n++) begin
            if (n == 20) hold_now = 1;
            if (n == 40) begin
                gap(1);
                wait (outstanding == 0);
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 1)) gap($urandom_range(1, 6));
            end
            burst--;
            send(random_request());
        end

        // long sound for the voice pool test
        long_id = n_defined;
        send(mk(REQ_APPEND, REGION_BASE, 0, 0, 17'(REGION_LEN), 0, 0, 0));
        if (long_id < NUM_SOUNDS) begin
            repeat (NUM_VOICES + 4)
                send(mk(REQ_START, 0, 0, 0, 0, 10'(long_id), 8'd255, 16'h0001));
        end
        repeat (4) send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0));

        gap(1);
        wait (outstanding == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("[multi_voice_sample_mixer] OK");
        else
            $display("[multi_voice_sample_mixer] ERROR");
        $finish;
    end

endmodule
